// ----- rtl/core/uart_boot_write_sequencer_macros.svh -----
// assertion macros for the uart boot write sequencer
`ifndef UART_BOOT_WRITE_SEQUENCER_MACROS_SVH
`define UART_BOOT_WRITE_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while arst_n is low
`define UBWS_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ubws: same-cycle check failed");
// next-cycle implication
`define UBWS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ubws: next-cycle check failed");
`else
`define UBWS_ASSERT_IMPLY(lbl, ante, cons)
`define UBWS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/core/ubws_pkg.sv -----
// types and codes shared by the uart boot write sequencer
`default_nettype none
package ubws_pkg;

	typedef logic [7:0]  byte_t;
	typedef logic [1:0]  op_t;
	typedef logic [1:0]  kind_t;
	typedef logic [1:0]  cfg_idx_t;
	typedef logic [31:0] word_t;
	typedef logic [20:0] size_t;
	typedef logic [8:0]  chunk_t;

	// request opcodes
	localparam op_t OP_START = 2'd0;
	localparam op_t OP_DATA  = 2'd1;
	localparam op_t OP_REPLY = 2'd2;

	// result kinds
	localparam kind_t KIND_TX   = 2'd0;
	localparam kind_t KIND_DONE = 2'd1;
	localparam kind_t KIND_FAIL = 2'd2;

	// register indexes
	localparam cfg_idx_t CFG_IMAGE_SIZE    = 2'd0;
	localparam cfg_idx_t CFG_START_ADDRESS = 2'd1;
	localparam cfg_idx_t CFG_WRITE_COMMAND = 2'd2;

	localparam byte_t ACK_BYTE       = 8'h79;
	localparam byte_t INVERT_MASK    = 8'hFF;
	localparam word_t RST_START_ADDR = 32'h0800_0000;
	localparam byte_t RST_WRITE_CMD  = 8'h31;

	// most results one request can cause
	localparam int MAX_RES = 5;

endpackage
`default_nettype wire

// ----- rtl/core/uart_boot_write_sequencer.sv -----
// top level of the uart boot write sequencer
`default_nettype none
`include "uart_boot_write_sequencer_macros.svh"
// Host side of a serial bootloader write-memory exchange. An OP_START request begins the image;
// each chunk of up to MAX_CHUNK bytes goes out as opcode and complement, wait for ACK, four
// address bytes MSB first and their XOR, wait for ACK, length minus one, the image bytes as
// they arrive, the XOR checksum, wait for ACK. A non-ACK reply fails for good; the end of the
// image reports done, and both hold until reset. Requests that do not fit the current phase
// are dropped without a result. Timing: a request is registered at the input, then in one
// pass sets the new state and loads all its results (up to five) into a result batch
// register, which hands out one result per cycle unless out_stall is high. With out_stall low,
// a request is taken every cycle while each gives at most one result; more results stall the
// input until the batch drains via the single-result output port. Registers are written through
// the cfg port, which is always ready, only while idle; the block leaves this to the user.
module uart_boot_write_sequencer #(
	parameter int MAX_CHUNK = 256,
	parameter int MAX_IMAGE = 1048576
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// request channel
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire ubws_pkg::op_t     op,
	input  wire ubws_pkg::byte_t   data_byte,
	// result channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output ubws_pkg::kind_t        kind,
	output ubws_pkg::byte_t        tx_byte,
	output logic                   last,
	// register write channel
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire ubws_pkg::cfg_idx_t cfg_index,
	input  wire ubws_pkg::word_t   cfg_data
);
	import ubws_pkg::*;

	// sequence phases
	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_CMD_ACK  = 3'd1;
	localparam logic [2:0] PH_ADDR_ACK = 3'd2;
	localparam logic [2:0] PH_DATA     = 3'd3;
	localparam logic [2:0] PH_DATA_ACK = 3'd4;
	localparam logic [2:0] PH_DONE     = 3'd5;
	localparam logic [2:0] PH_FAIL     = 3'd6;

	localparam int    RES_W      = $clog2(MAX_RES + 1);
	localparam int    IDX_W      = $clog2(MAX_RES);
	localparam size_t MaxImage   = size_t'(MAX_IMAGE);
	localparam size_t MaxChunkSz = size_t'(MAX_CHUNK);
	localparam chunk_t MaxChunk  = chunk_t'(MAX_CHUNK);

	// configuration registers
	size_t image_size_q;
	word_t start_address_q;
	byte_t write_command_q;

	// sequence state
	logic [2:0] phase_q;
	size_t      offset_q;
	word_t      addr_q;
	byte_t      xor_q;
	chunk_t     sent_q;
	chunk_t     clen_q;
	size_t      size_q;

	// input register
	logic  valid_s1;
	op_t   op_s1;
	byte_t data_s1;

	// result batch register
	logic [RES_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_q;
	kind_t            bkind_q;
	byte_t            bbyte_q [MAX_RES];

	// next-state and result logic
	logic [2:0]       phase_n;
	size_t            offset_n;
	word_t            addr_n;
	byte_t            xor_n;
	chunk_t           sent_n;
	chunk_t           clen_n;
	size_t            size_n;
	logic [RES_W-1:0] res_cnt;
	kind_t            res_kind;
	byte_t            res_byte [MAX_RES];

	size_t  remain;
	chunk_t clen_calc;
	chunk_t sent_inc;
	byte_t  xor_data;
	size_t  offset_sum;
	logic   is_ack;

	logic out_take;
	logic batch_free;
	logic s1_move;
	logic in_take;

	assign cfg_ready = 1'b1;

	// register writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q    <= '0;
			start_address_q <= RST_START_ADDR;
			write_command_q <= RST_WRITE_CMD;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_IMAGE_SIZE:    image_size_q    <= cfg_data[20:0];
				CFG_START_ADDRESS: start_address_q <= cfg_data;
				CFG_WRITE_COMMAND: write_command_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// handshakes: the batch frees up as its last result leaves
	assign out_valid  = (cnt_q != '0);
	assign out_take   = out_valid && !out_stall;
	assign batch_free = (cnt_q == '0) || (out_take && last);
	assign s1_move    = valid_s1 && batch_free;
	assign in_stall   = valid_s1 && !batch_free;
	assign in_take    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1   <= op;
			data_s1 <= data_byte;
		end
	end

	// chunk length from what is left of the image
	assign remain     = (size_q > offset_q) ? (size_q - offset_q) : size_t'(1);
	assign clen_calc  = (remain > MaxChunkSz) ? MaxChunk : remain[8:0];
	assign sent_inc   = sent_q + chunk_t'(1);
	assign xor_data   = xor_q ^ data_s1;
	assign offset_sum = offset_q + size_t'(clen_q);
	assign is_ack     = (data_s1 == ACK_BYTE);

	always_comb begin
		phase_n  = phase_q;
		offset_n = offset_q;
		addr_n   = addr_q;
		xor_n    = xor_q;
		sent_n   = sent_q;
		clen_n   = clen_q;
		size_n   = size_q;
		res_cnt  = '0;
		res_kind = KIND_TX;
		for (int i = 0; i < MAX_RES; i++) begin
			res_byte[i] = '0;
		end
		unique case (phase_q)
			PH_IDLE: begin
				if (op_s1 == OP_START) begin
					size_n   = (image_size_q > MaxImage) ? MaxImage : image_size_q;
					addr_n   = start_address_q;
					offset_n = '0;
					if (size_n == '0) begin
						res_cnt  = RES_W'(1);
						res_kind = KIND_DONE;
						phase_n  = PH_DONE;
					end else begin
						res_cnt     = RES_W'(2);
						res_byte[0] = write_command_q;
						res_byte[1] = write_command_q ^ INVERT_MASK;
						phase_n     = PH_CMD_ACK;
					end
				end
			end
			PH_CMD_ACK: begin
				if (op_s1 == OP_REPLY) begin
					if (!is_ack) begin
						res_cnt  = RES_W'(1);
						res_kind = KIND_FAIL;
						phase_n  = PH_FAIL;
					end else begin
						// address MSB first, then its xor
						res_cnt     = RES_W'(5);
						res_byte[0] = addr_q[31:24];
						res_byte[1] = addr_q[23:16];
						res_byte[2] = addr_q[15:8];
						res_byte[3] = addr_q[7:0];
						res_byte[4] = addr_q[31:24] ^ addr_q[23:16]
							^ addr_q[15:8] ^ addr_q[7:0];
						phase_n     = PH_ADDR_ACK;
					end
				end
			end
			PH_ADDR_ACK: begin
				if (op_s1 == OP_REPLY) begin
					if (!is_ack) begin
						res_cnt  = RES_W'(1);
						res_kind = KIND_FAIL;
						phase_n  = PH_FAIL;
					end else begin
						clen_n      = clen_calc;
						xor_n       = byte_t'(clen_calc - chunk_t'(1));
						sent_n      = '0;
						res_cnt     = RES_W'(1);
						res_byte[0] = xor_n;
						phase_n     = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				if (op_s1 == OP_DATA) begin
					xor_n       = xor_data;
					sent_n      = sent_inc;
					res_byte[0] = data_s1;
					if (sent_inc >= clen_q) begin
						res_cnt     = RES_W'(2);
						res_byte[1] = xor_data;
						phase_n     = PH_DATA_ACK;
					end else begin
						res_cnt = RES_W'(1);
					end
				end
			end
			PH_DATA_ACK: begin
				if (op_s1 == OP_REPLY) begin
					if (!is_ack) begin
						res_cnt  = RES_W'(1);
						res_kind = KIND_FAIL;
						phase_n  = PH_FAIL;
					end else begin
						addr_n   = addr_q + word_t'(clen_q);
						offset_n = offset_sum;
						if (offset_sum >= size_q) begin
							res_cnt  = RES_W'(1);
							res_kind = KIND_DONE;
							phase_n  = PH_DONE;
						end else begin
							res_cnt     = RES_W'(2);
							res_byte[0] = write_command_q;
							res_byte[1] = write_command_q ^ INVERT_MASK;
							phase_n     = PH_CMD_ACK;
						end
					end
				end
			end
			// done and failed hold until reset
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			offset_q <= '0;
			addr_q   <= '0;
			xor_q    <= '0;
			sent_q   <= '0;
			clen_q   <= '0;
			size_q   <= '0;
		end else if (s1_move) begin
			phase_q  <= phase_n;
			offset_q <= offset_n;
			addr_q   <= addr_n;
			xor_q    <= xor_n;
			sent_q   <= sent_n;
			clen_q   <= clen_n;
			size_q   <= size_n;
		end
	end

	// result batch: a request with no result loads an empty batch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (s1_move) begin
			cnt_q <= res_cnt;
			idx_q <= '0;
		end else if (out_take) begin
			// the last result empties the batch
			if (last) begin
				cnt_q <= '0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			bkind_q <= res_kind;
			bbyte_q <= res_byte;
		end
	end

	assign kind    = bkind_q;
	assign tx_byte = bbyte_q[idx_q];
	assign last    = (RES_W'(idx_q) == (cnt_q - RES_W'(1)));

	// the batch index stays inside the batch
	`UBWS_ASSERT_IMPLY(a_idx_in_batch, out_valid, RES_W'(idx_q) < cnt_q)
	// done and failed are final
	`UBWS_ASSERT_NEXT(a_done_sticky, phase_q == PH_DONE, phase_q == PH_DONE)
	`UBWS_ASSERT_NEXT(a_fail_sticky, phase_q == PH_FAIL, phase_q == PH_FAIL)
	// never more chunk bytes than the chunk holds
	`UBWS_ASSERT_IMPLY(a_chunk_count, phase_q == PH_DATA, sent_q < clen_q)

endmodule
`default_nettype wire

// ----- test/uart_boot_write_checker.sv -----
// checker that predicts and compares the transmit, done and fail results of the sequencer
`timescale 1ns / 1ps
module uart_boot_write_checker
	import ubws_pkg::*;
#(
	parameter int MAX_CHUNK = 256,
	parameter int MAX_IMAGE = 1048576
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_stall,
	input  op_t      op,
	input  byte_t    data_byte,
	input  logic     out_valid,
	input  logic     out_stall,
	input  kind_t    kind,
	input  byte_t    tx_byte,
	input  logic     last,
	input  logic     cfg_valid,
	input  logic     cfg_ready,
	input  cfg_idx_t cfg_index,
	input  word_t    cfg_data,
	output int       bad_results,
	output int       results_owed
);

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_CMD_ACK,
		SEQ_ADDR_ACK,
		SEQ_DATA,
		SEQ_DATA_ACK,
		SEQ_DONE,
		SEQ_FAIL
	} seq_phase_e;

	typedef struct packed {
		kind_t kind;
		byte_t tx_byte;
		logic  last;
	} link_result_t;

	// register copies
	size_t      cfg_size;
	word_t      cfg_addr;
	byte_t      cfg_cmd;

	// sequence state
	seq_phase_e seq;
	size_t      img_len;
	size_t      img_sent;
	word_t      dest_addr;
	byte_t      csum;
	chunk_t     chunk_fill;
	chunk_t     chunk_len;

	link_result_t staged[$];
	link_result_t owed_results[$];
	int           err_count;

	assign bad_results = err_count;

	task automatic flag(string what);
		if (err_count < 100)
			$display("%0t ns mismatch: %s", $time, what);
		err_count++;
	endtask

	task automatic put(kind_t k, byte_t b);
		staged.push_back('{k, b, 1'b0});
	endtask

	task automatic refuse();
		put(KIND_FAIL, 8'h00);
		seq = SEQ_FAIL;
	endtask

	task automatic open_chunk();
		put(KIND_TX, cfg_cmd);
		put(KIND_TX, cfg_cmd ^ INVERT_MASK);
		seq = SEQ_CMD_ACK;
	endtask

	task automatic advance_sequence(op_t o, byte_t b);
		size_t left;
		staged.delete();
		case (seq)
			SEQ_IDLE: begin
				if (o == OP_START) begin
					img_len   = (cfg_size > MAX_IMAGE) ? size_t'(MAX_IMAGE) : cfg_size;
					dest_addr = cfg_addr;
					img_sent  = '0;
					if (img_len == 0) begin
						put(KIND_DONE, 8'h00);
						seq = SEQ_DONE;
					end else begin
						open_chunk();
					end
				end
			end
			SEQ_CMD_ACK: begin
				if (o == OP_REPLY) begin
					if (b != ACK_BYTE) begin
						refuse();
					end else begin
						put(KIND_TX, dest_addr[31:24]);
						put(KIND_TX, dest_addr[23:16]);
						put(KIND_TX, dest_addr[15:8]);
						put(KIND_TX, dest_addr[7:0]);
						put(KIND_TX, dest_addr[31:24] ^ dest_addr[23:16] ^
							dest_addr[15:8] ^ dest_addr[7:0]);
						seq = SEQ_ADDR_ACK;
					end
				end
			end
			SEQ_ADDR_ACK: begin
				if (o == OP_REPLY) begin
					if (b != ACK_BYTE) begin
						refuse();
					end else begin
						left = (img_len > img_sent) ? size_t'(img_len - img_sent) : size_t'(1);
						chunk_len  = (left > MAX_CHUNK) ? chunk_t'(MAX_CHUNK) : chunk_t'(left);
						csum       = byte_t'(chunk_len - 9'd1);
						chunk_fill = '0;
						put(KIND_TX, csum);
						seq = SEQ_DATA;
					end
				end
			end
			SEQ_DATA: begin
				if (o == OP_DATA) begin
					csum       = csum ^ b;
					chunk_fill = chunk_fill + 9'd1;
					put(KIND_TX, b);
					if (chunk_fill >= chunk_len) begin
						put(KIND_TX, csum);
						seq = SEQ_DATA_ACK;
					end
				end
			end
			SEQ_DATA_ACK: begin
				if (o == OP_REPLY) begin
					if (b != ACK_BYTE) begin
						refuse();
					end else begin
						dest_addr = dest_addr + word_t'(chunk_len);
						img_sent  = img_sent + size_t'(chunk_len);
						if (img_sent >= img_len) begin
							put(KIND_DONE, 8'h00);
							seq = SEQ_DONE;
						end else begin
							open_chunk();
						end
					end
				end
			end
			default: ;
		endcase
		if (staged.size() != 0) begin
			staged[staged.size() - 1].last = 1'b1;
			foreach (staged[i])
				owed_results.push_back(staged[i]);
		end
	endtask

	task automatic check_result();
		link_result_t want;
		if (owed_results.size() == 0) begin
			flag($sformatf("kind %0d byte %02h last %0b with nothing owed", kind, tx_byte, last));
			return;
		end
		want = owed_results.pop_front();
		if (kind !== want.kind)
			flag($sformatf("kind %0d, wanted %0d", kind, want.kind));
		if (tx_byte !== want.tx_byte)
			flag($sformatf("tx_byte %02h, wanted %02h", tx_byte, want.tx_byte));
		if (last !== want.last)
			flag($sformatf("last %0b, wanted %0b", last, want.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_size   = '0;
			cfg_addr   = RST_START_ADDR;
			cfg_cmd    = RST_WRITE_CMD;
			seq        = SEQ_IDLE;
			img_len    = '0;
			img_sent   = '0;
			dest_addr  = '0;
			csum       = '0;
			chunk_fill = '0;
			chunk_len  = '0;
			owed_results.delete();
			results_owed <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_IMAGE_SIZE:    cfg_size = cfg_data[20:0];
					CFG_START_ADDRESS: cfg_addr = cfg_data;
					CFG_WRITE_COMMAND: cfg_cmd  = cfg_data[7:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				advance_sequence(op, data_byte);
			if (out_valid && !out_stall)
				check_result();
			results_owed <= owed_results.size();
		end
	end

endmodule

// ----- test/uart_boot_write_sequencer_tb.sv -----
// testbench top: drives one boot image write through the sequencer and gives the verdict
`timescale 1ns / 1ps
module uart_boot_write_sequencer_tb;
	import ubws_pkg::*;

	localparam int MAX_CHUNK   = 256;
	localparam int MAX_IMAGE   = 1048576;
	// generous bound: a few hundred requests, each at most five results under random stalls
	localparam int CYCLE_LIMIT = 300000;
	// cycles to let the block finish after the last owed result
	localparam int SETTLE_WAIT = 16;

	// op value the block never acts on
	localparam op_t OP_UNUSED = 2'd3;

	// which reply of the final chunk gets refused, if any
	localparam int STEP_CMD   = 0;
	localparam int STEP_ADDR  = 1;
	localparam int STEP_DATA  = 2;
	localparam int STEP_NONE  = 3;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_stall;
	op_t      op;
	byte_t    data_byte;
	logic     out_valid;
	logic     out_stall = 1'b0;
	kind_t    kind;
	byte_t    tx_byte;
	logic     last;
	logic     cfg_valid;
	logic     cfg_ready;
	cfg_idx_t cfg_index;
	word_t    cfg_data;

	int bad_results;
	int results_owed;
	int cycle_count = 0;

	// no idling and no stalls while set
	bit quiet = 1'b0;

	uart_boot_write_sequencer #(
		.MAX_CHUNK(MAX_CHUNK),
		.MAX_IMAGE(MAX_IMAGE)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.tx_byte(tx_byte),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	uart_boot_write_checker #(
		.MAX_CHUNK(MAX_CHUNK),
		.MAX_IMAGE(MAX_IMAGE)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.tx_byte(tx_byte),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.bad_results(bad_results),
		.results_owed(results_owed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver side: random stalls, drawn with a chance of about nine in a hundred
	always @(posedge clk) begin
		out_stall <= !quiet && ($urandom_range(0, 99) < 9);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// one request, with an occasional idle gap in front; valid stays high on return
	// so the caller either presents the next request or drops valid in the same step
	task automatic send(op_t o, byte_t b);
		if (!quiet && $urandom_range(0, 99) < 9) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		op        <= o;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
	endtask

	// a request the block must ignore in the current phase; in_data picks the data phase
	task automatic stray(bit in_data);
		op_t o;
		case ($urandom_range(0, 2))
			0:       o = OP_UNUSED;
			1:       o = OP_START;
			default: o = in_data ? OP_REPLY : OP_DATA;
		endcase
		send(o, byte_t'($urandom_range(0, 255)));
	endtask

	// target reply while an ack is awaited: the ack byte, or any other byte to refuse
	task automatic answer(bit refuse);
		byte_t b;
		if ($urandom_range(0, 9) == 0)
			stray(1'b0);
		b = ACK_BYTE;
		if (refuse) begin
			b = byte_t'($urandom_range(0, 254));
			if (b >= ACK_BYTE)
				b = b + 8'd1;
		end
		send(OP_REPLY, b);
	endtask

	// stop sending until every owed result is out and the block has gone quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, word_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// all three registers; valid is left high, the caller drops it after the last batch
	task automatic load_regs(word_t size, word_t addr, byte_t cmd);
		write_reg(CFG_IMAGE_SIZE, size);
		write_reg(CFG_START_ADDRESS, addr);
		write_reg(CFG_WRITE_COMMAND, word_t'(cmd));
	endtask

	initial begin : stimulus
		op_t   any_op [4] = '{OP_START, OP_DATA, OP_REPLY, OP_UNUSED};
		// first image bytes: the extremes and patterns with a single bit set or a single bit clear
		byte_t opening [6] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE};
		int    img_bytes;
		word_t base_addr;
		int    img_off;
		int    chunk;
		int    n;
		int    fail_step;
		int    kill;
		bit    last_chunk;
		byte_t b;

		in_valid  <= 1'b0;
		op        <= OP_START;
		data_byte <= 8'h00;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_IMAGE_SIZE;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// the outcome sticks until reset, so one image per run; mostly two chunks, sometimes
		// two full chunks and a single-byte third one (length byte 255 and then 0)
		img_bytes = ($urandom_range(0, 3) == 0) ? 2 * MAX_CHUNK + 1 : $urandom_range(420, 470);
		case ($urandom_range(0, 3))
			0:       base_addr = 32'hFFFF_FF80;  // address wraps past the top mid-image
			1:       base_addr = 32'h0000_0000;
			2:       base_addr = RST_START_ADDR;
			default: base_addr = word_t'($urandom);
		endcase
		// about one seed in three ends on a refused reply in the final chunk
		fail_step = ($urandom_range(0, 2) == 0) ? $urandom_range(STEP_CMD, STEP_DATA) : STEP_NONE;

		// extremes first, then the values this image runs with
		load_regs(word_t'(MAX_IMAGE), 32'hFFFF_FFFF, 8'h00);
		load_regs(word_t'(img_bytes), base_addr, byte_t'($urandom_range(0, 255)));
		cfg_valid <= 1'b0;

		// idle: only a start is taken
		send(OP_DATA, 8'hFF);
		send(OP_REPLY, 8'h00);
		send(OP_REPLY, ACK_BYTE);
		send(OP_UNUSED, 8'h5A);
		send(OP_START, byte_t'($urandom_range(0, 255)));
		// waiting for the opcode ack: a second start, a data byte and an unused op are dropped
		send(OP_START, 8'hFF);
		send(OP_DATA, 8'h00);
		send(OP_UNUSED, 8'hA5);

		img_off = 0;
		chunk   = 0;
		while (img_off < img_bytes) begin
			n          = (img_bytes - img_off > MAX_CHUNK) ? MAX_CHUNK : img_bytes - img_off;
			last_chunk = (img_off + n >= img_bytes);
			kill       = last_chunk ? fail_step : STEP_NONE;
			// second chunk runs with no idling or stalls at all
			quiet = (chunk == 1);

			answer(kill == STEP_CMD);
			if (kill == STEP_CMD)
				break;
			answer(kill == STEP_ADDR);
			if (kill == STEP_ADDR)
				break;

			for (int i = 0; i < n; i++) begin
				if (chunk == 0 && i == 2) begin
					// data phase: replies, even the ack byte, and starts are dropped
					send(OP_REPLY, ACK_BYTE);
					send(OP_REPLY, 8'hFF);
					send(OP_START, 8'h00);
					send(OP_UNUSED, 8'hFF);
				end else if ($urandom_range(0, 9) == 0) begin
					stray(1'b1);
				end
				b = (chunk == 0 && i < 6) ? opening[i] : byte_t'($urandom_range(0, 255));
				send(OP_DATA, b);
			end

			if (!last_chunk) begin
				// data ack still outstanding: change the registers between chunks; only the
				// opcode is picked up by the next chunk, size and address were taken at start
				settle();
				if (chunk == 0)
					load_regs(word_t'(MAX_IMAGE), 32'h0000_0000, 8'h00);
				else
					load_regs(32'h0000_0000, 32'hFFFF_FFFF, 8'hFF);
				cfg_valid <= 1'b0;
			end

			answer(kill == STEP_DATA);
			if (kill == STEP_DATA)
				break;
			img_off += n;
			chunk++;
		end
		quiet = 1'b0;

		// done or failed holds: everything after is dropped, a start too
		repeat (12)
			send(any_op[$urandom_range(0, 3)], byte_t'($urandom_range(0, 255)));
		settle();

		if (bad_results == 0 && results_owed == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/ubws_pkg.sv
rtl/core/uart_boot_write_sequencer.sv
test/uart_boot_write_checker.sv
test/uart_boot_write_sequencer_tb.sv
